// ===== rtl/stre_pkg.sv =====
// shared types and command codes for the sparse table range max engine
`timescale 1ns / 1ps
`default_nettype none
package stre_pkg;

  localparam int POS_BITS  = 10;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RMAX = 2'd1;
  localparam logic [1:0] CMD_FGT  = 2'd2;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [POS_BITS-1:0]  low_pos;
    logic [POS_BITS-1:0]  high_pos;
    logic [DATA_BITS-1:0] datum;
    logic                 last_load;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] max_value;
    logic [POS_BITS-1:0]  hit_index;
    logic                 found;
    logic                 bad_query;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/sparse_table_range_max_engine.sv =====
// Sparse table range max engine, top level.
// Items on req carry a command: load an element, range maximum over
// [low_pos, high_pos], or lowest index in the interval above a threshold.
// A load returns nothing; the load marked last_load sets the length and
// builds each level whose window fits the length; req_ready is then low.
// A range max query makes one table read per window of the capped
// power-of-two size. A first-greater query runs one range max over the
// interval and then one per bisection step, about log2(length) + 1 of
// them, each limited by the single table read port.
// Each query returns exactly one item on rsp through an output register;
// a new item is taken while a result still waits there, but a following
// query holds its result until the register is free.
// Reset clears the length and the built flag; table contents are left as
// they are and every query gives bad_query until a last load.
`timescale 1ns / 1ps
`default_nettype none
module sparse_table_range_max_engine import stre_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_BITS   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  logic res_valid, res_room;
  rsp_t res;

  stre_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .req_ready(req_ready),
    .res_room (res_room),
    .res_valid(res_valid),
    .res      (res)
  );

  // output register
  assign res_room = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_room) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_room && res_valid) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stre_ram.sv =====
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
`default_nettype none
module stre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/stre_ctrl.sv =====
// sequencer for load, table build, range max and first-greater search
`timescale 1ns / 1ps
`default_nettype none
module stre_ctrl import stre_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_BITS   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire req_t req,
  output logic      req_ready,
  input  wire logic res_room,
  output logic      res_valid,
  output rsp_t      res
);

  localparam int IW    = $clog2(MAX_ELEMENTS);
  localparam int LVW   = $clog2(LEVELS);
  localparam int AW    = LVW + IW;
  localparam int DEPTH = LEVELS * (2 ** IW);
  localparam int CW0   = $clog2(MAX_ELEMENTS + 1);
  localparam int PA    = (CW0 > POS_BITS) ? CW0 : POS_BITS;
  localparam int PW    = ((PA > LEVELS) ? PA : LEVELS) + 1;
  localparam int JW    = $clog2(LEVELS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BLVL  = 4'd1;
  localparam logic [3:0] S_BRA   = 4'd2;
  localparam logic [3:0] S_BRB   = 4'd3;
  localparam logic [3:0] S_BWR   = 4'd4;
  localparam logic [3:0] S_RSET  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RWT   = 4'd7;
  localparam logic [3:0] S_RDONE = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]            state;
  logic [PW-1:0]         count;
  logic                  built;
  logic [JW-1:0]         bj;
  logic [PW-1:0]         bi;
  logic [VALUE_BITS-1:0] aval;
  logic [PW-1:0]         ra, rb, rp, rw;
  logic [LVW-1:0]        rk;
  logic                  rlast;
  logic [VALUE_BITS-1:0] rm;
  logic [VALUE_BITS-1:0] thr;
  logic                  fgt, bis;
  logic [PW-1:0]         ba, bb;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  logic [PW-1:0]         lo_p, hi_p, bw, bhalf, rlen, na, nb;
  logic [LVW-1:0]        rlen_k;
  logic [VALUE_BITS-1:0] rm_new;
  logic                  take, rtail;

  function automatic logic [LVW-1:0] klog(input logic [PW-1:0] v);
    int r;
    r = 0;
    for (int i = 0; i < PW; i++) begin
      if (v[i]) r = i;
    end
    if (r > LEVELS - 1) r = LEVELS - 1;
    return LVW'(r);
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic [LVW-1:0] lv,
                                            input logic [PW-1:0] idx);
    return {lv, IW'(idx)};
  endfunction

  stre_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // helper values
  assign req_ready = (state == S_IDLE);
  assign take      = req_valid && req_ready;
  assign lo_p      = PW'(req.low_pos);
  assign hi_p      = PW'(req.high_pos);
  assign bw        = PW'(1) << bj;
  assign bhalf     = PW'(1) << (bj - JW'(1));
  assign rlen      = rb - ra + PW'(1);
  assign rlen_k    = klog(rlen);
  assign rtail     = (rp + rw - PW'(1)) >= rb;
  assign rm_new    = (mem_rdata > rm) ? mem_rdata : rm;
  assign res_valid = (state == S_DONE);
  // next bisection bounds from the half just measured
  assign na        = (rm > thr) ? ba : rb + PW'(1);
  assign nb        = (rm > thr) ? rb : bb;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mk_addr(LVW'(0), lo_p);
    mem_wdata = VALUE_BITS'(req.datum);
    mem_raddr = mk_addr(LVW'(bj - JW'(1)), bi);
    unique case (state)
      S_IDLE: begin
        mem_we = take && (req.cmd == CMD_LOAD) && (lo_p < PW'(MAX_ELEMENTS));
      end
      S_BRB: begin
        mem_raddr = mk_addr(LVW'(bj - JW'(1)), bi + bhalf);
      end
      S_BWR: begin
        mem_we    = 1'b1;
        mem_waddr = mk_addr(LVW'(bj), bi);
        mem_wdata = (aval > mem_rdata) ? aval : mem_rdata;
      end
      S_RRD: begin
        mem_raddr = rtail ? mk_addr(rk, rb - rw + PW'(1)) : mk_addr(rk, rp);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      built <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            case (req.cmd)
              CMD_LOAD: begin
                if (req.last_load) begin
                  count <= (lo_p < PW'(MAX_ELEMENTS)) ? lo_p + PW'(1) : PW'(MAX_ELEMENTS);
                  built <= 1'b1;
                  bj    <= JW'(1);
                  state <= S_BLVL;
                end else begin
                  built <= 1'b0;
                end
              end
              CMD_RMAX, CMD_FGT: begin
                if (!built || lo_p > hi_p || hi_p >= count) begin
                  res   <= '{max_value: '0, hit_index: '0, found: 1'b0,
                             bad_query: 1'b1};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  ra    <= lo_p;
                  rb    <= hi_p;
                  fgt   <= (req.cmd == CMD_FGT);
                  bis   <= 1'b0;
                  thr   <= VALUE_BITS'(req.datum);
                  state <= S_RSET;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // level loop of the build
        S_BLVL: begin
          if (bj < JW'(LEVELS) && bw <= count) begin
            bi    <= '0;
            state <= S_BRA;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BRA: state <= S_BRB;
        S_BRB: begin
          aval  <= mem_rdata;
          state <= S_BWR;
        end
        S_BWR: begin
          if (bi + PW'(1) + bw <= count) begin
            bi    <= bi + PW'(1);
            state <= S_BRA;
          end else begin
            bj    <= bj + JW'(1);
            state <= S_BLVL;
          end
        end
        // window walk for one range max
        S_RSET: begin
          rk    <= rlen_k;
          rw    <= PW'(1) << rlen_k;
          rp    <= ra;
          rm    <= '0;
          state <= S_RRD;
        end
        S_RRD: begin
          rlast <= rtail;
          rp    <= rp + rw;
          state <= S_RWT;
        end
        S_RWT: begin
          rm    <= rm_new;
          state <= rlast ? S_RDONE : S_RRD;
        end
        // dispatch on a finished range max
        S_RDONE: begin
          if (!fgt) begin
            res   <= '{max_value: DATA_BITS'(rm), hit_index: '0, found: 1'b0,
                       bad_query: 1'b0};
            state <= S_DONE;
          end else if (!bis) begin
            if (rm > thr) begin
              if (ra == rb) begin
                res   <= '{max_value: '0, hit_index: POS_BITS'(ra), found: 1'b1,
                           bad_query: 1'b0};
                state <= S_DONE;
              end else begin
                bis   <= 1'b1;
                ba    <= ra;
                bb    <= rb;
                rb    <= ra + ((rb - ra) >> 1);
                state <= S_RSET;
              end
            end else begin
              state <= S_DONE;
            end
          end else if (na < nb) begin
            ba    <= na;
            bb    <= nb;
            ra    <= na;
            rb    <= na + ((nb - na) >> 1);
            state <= S_RSET;
          end else begin
            res   <= '{max_value: '0, hit_index: POS_BITS'(na), found: 1'b1,
                       bad_query: 1'b0};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_room) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_BWR))
    else $error("table write outside load or build");
  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.found && res.bad_query))
    else $error("found and bad set together");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RRD) |-> (rp <= rb))
    else $error("window walk past interval end");
  a_built_count: assert property (@(posedge clk) disable iff (rst)
    (built && state == S_IDLE) |-> (count != '0))
    else $error("table marked built with no elements");

endmodule
`default_nettype wire

// ===== tb/range_max_monitor.sv =====
// monitor that predicts and checks every response of the range max engine
`timescale 1ns / 1ps
module range_max_monitor import stre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   error_count,
  output int   pending
);

  localparam int ARRAY_DEPTH = 1024;

  // predictor copy of the loaded array, its length and the build flag
  logic [DATA_BITS-1:0] elem_mem [ARRAY_DEPTH];
  int unsigned          elem_len = 0;
  bit                   table_ready = 0;
  rsp_t                 awaited_rsp [$];

  assign pending = awaited_rsp.size();

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    error_count++;
  endtask

  // expected response of one range max or first-greater query
  function automatic rsp_t answer_query(req_t r);
    rsp_t a;
    int unsigned idx;
    a = '0;
    if (!table_ready || r.low_pos > r.high_pos || r.high_pos >= elem_len) begin
      a.bad_query = 1'b1;
    end else if (r.cmd == CMD_RMAX) begin
      for (idx = r.low_pos; idx <= r.high_pos; idx++)
        if (elem_mem[idx] > a.max_value) a.max_value = elem_mem[idx];
    end else begin
      for (idx = r.low_pos; idx <= r.high_pos && !a.found; idx++)
        if (elem_mem[idx] > r.datum) begin
          a.found     = 1'b1;
          a.hit_index = idx[POS_BITS-1:0];
        end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      elem_len    = 0;
      table_ready = 0;
      awaited_rsp.delete();
    end else begin
      // compare a delivered response with the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $display("unexpected response at %0t", $realtime);
          error_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.max_value !== want.max_value)
            report_mismatch("max_value", rsp.max_value, want.max_value);
          if (rsp.hit_index !== want.hit_index)
            report_mismatch("hit_index", rsp.hit_index, want.hit_index);
          if (rsp.found !== want.found)
            report_mismatch("found", rsp.found, want.found);
          if (rsp.bad_query !== want.bad_query)
            report_mismatch("bad_query", rsp.bad_query, want.bad_query);
        end
      end
      // update the model on an accepted item
      if (req_valid && req_ready) begin
        case (req.cmd)
          CMD_LOAD: begin
            elem_mem[req.low_pos] = req.datum;
            if (req.last_load) begin
              elem_len    = req.low_pos + 1;
              table_ready = 1;
            end else begin
              table_ready = 0;
            end
          end
          CMD_RMAX, CMD_FGT: awaited_rsp.push_back(answer_query(req));
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the sparse table range max engine
`timescale 1ns / 1ps
module testbench;
  import stre_pkg::*;

  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam int         ITEM_GOAL = 1900;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  int   error_count;
  int   pending;

  int   items_sent = 0;
  int   rsp_seen = 0;
  bit   quiet_send = 0;
  logic [31:0] vals [1024];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  sparse_table_range_max_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  range_max_monitor mon (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .error_count(error_count), .pending(pending)
  );

  // hard limit on run length
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // offer one item, after a random gap unless quiet_send is set, and hold it until accepted
  task automatic send_item(logic [1:0] cmd, int lo, int hi, logic [31:0] datum, bit last);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= '{cmd: cmd, low_pos: lo[9:0], high_pos: hi[9:0], datum: datum,
                   last_load: last};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  // let the monitor see the last accepted item, then wait for no pending response
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // load positions 0..n-1, the last one marked final
  task automatic load_array(int n);
    int p;
    for (p = 0; p < n; p++) begin
      vals[p] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20);
      send_item(CMD_LOAD, p, $urandom_range(0, 1023), vals[p], p == n - 1);
    end
  endtask

  // threshold at or just below a value of the interval, or random, zero or all ones
  function automatic logic [31:0] pick_threshold(int lo, int hi);
    logic [31:0] t;
    t = vals[$urandom_range(lo, hi)];
    case ($urandom_range(0, 5))
      0: return t;
      1: return (t == 0) ? t : t - 1;
      2: return $urandom();
      3: return 32'd0;
      4: return 32'hFFFF_FFFF;
      default: return t;
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, and a stretch with none
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = (rsp_seen > 500 && rsp_seen < 620) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      rsp_seen++;
      if (rsp_seen == 150) begin
        rsp_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  initial begin
    int set_idx, n, nq, q, kind, lo, hi, p;
    bit big_set;
    logic [1:0] qcmd;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: queries before any build, ignored command
    send_item(CMD_RMAX, 0, 0, 32'd0, 0);
    send_item(CMD_FGT, 0, 1023, 32'd0, 0);
    send_item(CMD_NONE, 1023, 1023, 32'hFFFF_FFFF, 1);
    // small array with extreme values
    vals[0] = 32'd0; vals[1] = 32'hFFFF_FFFF; vals[2] = 32'd5; vals[3] = 32'd7;
    for (p = 0; p < 4; p++) send_item(CMD_LOAD, p, 0, vals[p], p == 3);
    send_item(CMD_RMAX, 0, 3, 32'd0, 0);
    send_item(CMD_RMAX, 2, 2, 32'd0, 0);
    send_item(CMD_RMAX, 3, 2, 32'd0, 0);        // empty interval
    send_item(CMD_RMAX, 0, 4, 32'd0, 0);        // past the loaded length
    send_item(CMD_FGT, 0, 3, 32'd0, 0);
    send_item(CMD_FGT, 0, 3, 32'hFFFF_FFFF, 0);  // nothing above
    send_item(CMD_FGT, 2, 3, 32'd5, 0);
    send_item(CMD_FGT, 2, 3, 32'd6, 0);
    // a load without the final mark makes queries bad until a rebuild
    send_item(CMD_LOAD, 2, 0, 32'd9, 0);
    send_item(CMD_RMAX, 0, 3, 32'd0, 0);
    vals[2] = 32'd9;
    send_item(CMD_LOAD, 3, 0, vals[3], 1);
    send_item(CMD_RMAX, 0, 3, 32'd0, 0);
    send_item(CMD_FGT, 0, 3, 32'd8, 0);
    wait_drained();

    // random sets: load an array, then mostly well-formed queries
    set_idx = 0;
    while (items_sent < ITEM_GOAL) begin
      big_set = (set_idx == 4);
      n = big_set ? 1024 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
                                                       : $urandom_range(5, 48));
      if (big_set || set_idx % 10 == 0) wait_drained();
      quiet_send = big_set || (set_idx % 6 == 5);
      load_array(n);
      nq = big_set ? 40 : $urandom_range(4, 30);
      for (q = 0; q < nq; q++) begin
        kind = $urandom_range(0, 19);
        if (big_set && q == 0) begin
          send_item(CMD_RMAX, 0, 1023, 32'd0, 0);
          send_item(CMD_FGT, 0, 1023, pick_threshold(0, 1023), 0);
        end else if (kind == 0) begin
          send_item(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom(), $urandom_range(0, 1));
        end else if (kind == 1) begin
          qcmd = $urandom_range(0, 1) ? CMD_RMAX : CMD_FGT;
          if (n < 1024 && $urandom_range(0, 1))
            send_item(qcmd, $urandom_range(0, n - 1), $urandom_range(n, 1023),
                      $urandom(), 0);
          else if (n > 1) begin
            hi = $urandom_range(0, n - 2);
            send_item(qcmd, $urandom_range(hi + 1, 1023), hi, $urandom(), 0);
          end
        end else if (kind == 2) begin
          p = $urandom_range(0, n - 1);
          vals[p] = $urandom();
          send_item(CMD_LOAD, p, $urandom_range(0, 1023), vals[p], 0);
          send_item(CMD_FGT, 0, n - 1, 32'd0, 0);
          send_item(CMD_LOAD, n - 1, $urandom_range(0, 1023), vals[n - 1], 1);
        end else begin
          lo = $urandom_range(0, n - 1);
          hi = $urandom_range(lo, n - 1);
          if ($urandom_range(0, 1))
            send_item(CMD_RMAX, lo, hi, $urandom(), 0);
          else
            send_item(CMD_FGT, lo, hi, pick_threshold(lo, hi), 0);
        end
      end
      set_idx++;
    end
    quiet_send = 0;

    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stre_pkg.sv
rtl/stre_ram.sv
rtl/stre_ctrl.sv
rtl/sparse_table_range_max_engine.sv
tb/range_max_monitor.sv
tb/testbench.sv
